>>> src/binary_max_heap_queue_macros.svh
// ---------------------------------------------------------------------------
// binary_max_heap_queue_macros
// Assertion macros for the heap queue; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define BMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 11;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHECK,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,       // start sift-up: hole at the tail, count up
        DP_POP,        // count down, read the tail entry
        DP_ERR_EMPTY,
        DP_ERR_FULL,
        DP_HOLE,       // take the tail entry as the moving value, hole at root
        DP_UP_RD,      // read the parent of the hole
        DP_UP_MOVE,    // move parent down into the hole
        DP_DN_RD,      // read both children of the hole
        DP_DN_MOVE,    // move the larger child up into the hole
        DP_PLACE       // write the moving value into the hole
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic leaf;
        logic up_go;
        logic dn_go;
    } t_dp_sts;

endpackage

>>> src/bmhq_ctrl.sv
// ---------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer of the heap queue: steps the datapath through at most one sift per
// item and owns the input ready and the result valid.
// ---------------------------------------------------------------------------
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_op,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_PUSH) begin
                        n_state = i_sts.full ? S_DONE : S_UP_CHECK;
                    end else begin
                        n_state = i_sts.empty ? S_DONE : S_DN_LOAD;
                    end
                end
            end
            S_UP_CHECK: n_state = i_sts.pos_zero ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = i_sts.up_go ? S_UP_CHECK : S_DONE;
            S_DN_LOAD:  n_state = S_DN_CHECK;
            S_DN_CHECK: n_state = i_sts.leaf ? S_DONE : S_DN_CMP;
            S_DN_CMP:   n_state = i_sts.dn_go ? S_DN_CHECK : S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = DP_NOP;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_PUSH) begin
                        o_cmd.op = i_sts.full ? DP_ERR_FULL : DP_PUSH;
                    end else begin
                        o_cmd.op = i_sts.empty ? DP_ERR_EMPTY : DP_POP;
                    end
                end
            end
            S_UP_CHECK: o_cmd.op = i_sts.pos_zero ? DP_PLACE : DP_UP_RD;
            S_UP_CMP:   o_cmd.op = i_sts.up_go ? DP_UP_MOVE : DP_PLACE;
            S_DN_LOAD:  o_cmd.op = DP_HOLE;
            S_DN_CHECK: o_cmd.op = i_sts.leaf ? DP_PLACE : DP_DN_RD;
            S_DN_CMP:   o_cmd.op = i_sts.dn_go ? DP_DN_MOVE : DP_PLACE;
            S_DONE:     o_cmd.load_out = w_out_free;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/bmhq_datapath.sv
// ---------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, entry count, hole position and moving value, compare logic
// and the result register of the heap queue.
// ---------------------------------------------------------------------------
module bmhq_datapath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic signed [VALUE_W-1:0] o_top_value,
    output logic [COUNT_OUT_W-1:0]    o_count,
    output logic                      o_is_empty,
    output logic [1:0]                o_status
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = AW + 1;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_pos;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] r_root;
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_b;
    t_status                   r_status;

    logic signed [VALUE_W-1:0] r_out_top;
    logic [COUNT_OUT_W-1:0]    r_out_count;
    logic                      r_out_empty;
    t_status                   r_out_status;

    logic [CW-1:0]             w_cnt_m1;
    logic [AW-1:0]             w_parent;
    logic [CHW-1:0]            w_child;
    logic [CHW-1:0]            w_child_r;
    logic                      w_right_sel;
    logic signed [VALUE_W-1:0] w_big;
    logic [AW-1:0]             w_big_addr;
    logic [AW-1:0]             w_raddr_a;
    logic [AW-1:0]             w_raddr_b;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;

    assign w_cnt_m1  = r_count - 1'b1;
    assign w_parent  = (r_pos - 1'b1) >> 1;
    assign w_child   = {r_pos, 1'b1};
    assign w_child_r = w_child + 1'b1;

    // right child wins only when it exists and is strictly larger
    assign w_right_sel = (w_child_r < CHW'(r_count)) && (r_rd_b > r_rd_a);
    assign w_big       = w_right_sel ? r_rd_b : r_rd_a;
    assign w_big_addr  = w_right_sel ? w_child_r[AW-1:0] : w_child[AW-1:0];

    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.leaf     = (w_child >= CHW'(r_count));
    assign o_sts.up_go    = (r_val > r_rd_a);
    assign o_sts.dn_go    = (w_big > r_val);

    always_comb begin
        case (i_cmd.op)
            DP_POP:   w_raddr_a = w_cnt_m1[AW-1:0];
            DP_UP_RD: w_raddr_a = w_parent;
            default:  w_raddr_a = w_child[AW-1:0];
        endcase
        w_raddr_b = w_child_r[AW-1:0];
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_val;
        case (i_cmd.op)
            DP_PLACE: begin
                w_we = 1'b1;
            end
            DP_UP_MOVE: begin
                w_we    = 1'b1;
                w_wdata = r_rd_a;
            end
            DP_DN_MOVE: begin
                w_we    = 1'b1;
                w_wdata = w_big;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= mem[w_raddr_a];
        r_rd_b <= mem[w_raddr_b];
    end

    // shadow of the root entry, kept in step with every write to address zero
    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                DP_PUSH: r_count <= r_count + 1'b1;
                DP_POP:  r_count <= w_cnt_m1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_PUSH: begin
                r_pos    <= r_count[AW-1:0];
                r_val    <= i_value;
                r_status <= ST_OK;
            end
            DP_POP:       r_status <= ST_OK;
            DP_ERR_EMPTY: r_status <= ST_POP_EMPTY;
            DP_ERR_FULL:  r_status <= ST_PUSH_FULL;
            DP_HOLE: begin
                r_pos <= '0;
                r_val <= r_rd_a;
            end
            DP_UP_MOVE:   r_pos <= w_parent;
            DP_DN_MOVE:   r_pos <= w_big_addr;
            default:      r_pos <= r_pos;
        endcase
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_top    <= o_sts.empty ? '0 : r_root;
            r_out_count  <= w_count_ext[COUNT_OUT_W-1:0];
            r_out_empty  <= o_sts.empty;
            r_out_status <= r_status;
        end
    end

    assign o_top_value = r_out_top;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_out_empty;
    assign o_status    = r_out_status;

endmodule

>>> src/binary_max_heap_queue.sv
// A max-priority queue of signed 32-bit values held as a binary heap in a
// CAPACITY-entry memory. Each input transfer carries an operation in s_tuser
// (0 push, 1 pop) and a value in s_tdata; each produces exactly one result
// transfer with the new maximum, the entry count, an empty flag and a status
// (0 ok, 1 pop on empty ignored, 2 push on full ignored). One item is in work
// at a time: s_tready is high only between items. A push sifts its value up
// from the tail, a pop moves the tail entry to the root and sifts it down;
// each heap level the entry moves costs a read of the heap memory and then a
// compare-and-write, and error cases go straight to the result register.
// s_tready returns in the cycle after the result is loaded. The result
// register lets the next item be accepted while a result waits to be taken.
// ---------------------------------------------------------------------------
// binary_max_heap_queue
// Top level: stream ports, sequencer and datapath of the heap queue.
// ---------------------------------------------------------------------------
`include "binary_max_heap_queue_macros.svh"

module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] top_value, [42:32] count,
                                   // [43] is_empty, [45:44] status, [47:46] zero
);

    t_dp_cmd                   w_cmd;
    t_dp_sts                   w_sts;
    logic signed [VALUE_W-1:0] w_top_value;
    logic [COUNT_OUT_W-1:0]    w_count;
    logic                      w_is_empty;
    logic [1:0]                w_status;

    bmhq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_op        (s_tuser[0]),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (s_tdata),
        .o_top_value (w_top_value),
        .o_count     (w_count),
        .o_is_empty  (w_is_empty),
        .o_status    (w_status)
    );

    assign m_tdata = {2'b00, w_status, w_is_empty, w_count, w_top_value};

    // result register is loaded only when it is free or being drained
    `BMHQ_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out, (!m_tvalid || m_tready), "result overwritten before transfer")

    // push on a full queue leaves it full
    `BMHQ_ASSERT_NEXT(a_full_push_holds, i_clk, i_rst_n, (s_tvalid && s_tready && (s_tuser[0] == OP_PUSH) && w_sts.full), w_sts.full, "push on full queue changed the count")

    // a successful pop leaves room for a push
    `BMHQ_ASSERT_NEXT(a_pop_frees_slot, i_clk, i_rst_n, (s_tvalid && s_tready && (s_tuser[0] == OP_POP) && !w_sts.empty), !w_sts.full, "queue still full after a pop")

endmodule

>>> test/tb_binary_max_heap_queue.sv
// ---------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Streams push and pop transfers into the heap queue and checks every result
// against a behavioral max-heap kept in the bench: directed corner cases,
// random mixes that grow the heap deep and drain it again, random stalls.
// ---------------------------------------------------------------------------
module tb_binary_max_heap_queue
    import bmhq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = 1024;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic        op;
        logic [31:0] value;
        bit          hold_for_drain;   // wait until every result is back
    } t_heap_req;

    typedef struct {
        logic signed [31:0] top;
        logic [10:0]        count;
        logic               empty;
        t_status            status;
    } t_heap_result;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [0:0]  s_tuser  = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] top_value, [42:32] count,
                                  // [43] is_empty, [45:44] status

    binary_max_heap_queue #(.CAPACITY(HEAP_DEPTH)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    t_heap_req    req_q[$];
    t_heap_result top_expect_q[$];

    // shadow heap
    logic signed [31:0] model_heap [HEAP_DEPTH];
    int                 model_count = 0;

    int n_items      = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_pushes     = 0;
    int n_pops       = 0;
    int n_push_full  = 0;
    int n_pop_empty  = 0;
    int peak_count   = 0;
    int mismatches   = 0;
    int cyc          = 0;
    int stall_cycles = 0;
    bit calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_heap_result heap_apply(logic op, logic signed [31:0] val);
        t_heap_result       r;
        int                 pos;
        int                 parent;
        int                 child;
        int                 last;
        logic signed [31:0] tmp;
        r.status = ST_OK;
        if (op == OP_PUSH) begin
            n_pushes++;
            if (model_count >= HEAP_DEPTH) begin
                r.status = ST_PUSH_FULL;
                n_push_full++;
            end else begin
                pos = model_count;
                model_heap[pos] = val;
                model_count++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (model_heap[pos] <= model_heap[parent]) break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[parent];
                    model_heap[parent] = tmp;
                    pos = parent;
                end
            end
        end else begin
            n_pops++;
            if (model_count == 0) begin
                r.status = ST_POP_EMPTY;
                n_pop_empty++;
            end else begin
                last = model_count - 1;
                model_heap[0] = model_heap[last];
                model_count = last;
                pos = 0;
                forever begin
                    child = 2 * pos + 1;
                    if (child >= last) break;
                    // ties go to the left child
                    if (child + 1 < last && model_heap[child + 1] > model_heap[child])
                        child = child + 1;
                    if (model_heap[child] <= model_heap[pos]) break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[child];
                    model_heap[child] = tmp;
                    pos = child;
                end
            end
        end
        if (model_count > peak_count) peak_count = model_count;
        r.top   = (model_count > 0) ? model_heap[0] : '0;
        r.count = 11'(model_count);
        r.empty = (model_count == 0);
        return r;
    endfunction

    function automatic void queue_item(logic op, logic [31:0] v);
        t_heap_req req;
        req.op             = op;
        req.value          = v;
        req.hold_for_drain = 1'b0;
        req_q.insert(req_q.size(), req);
        n_items++;
    endfunction

    // hold the sender until every expected result has come back
    function automatic void queue_drain_pause();
        t_heap_req req;
        req.op             = OP_PUSH;
        req.value          = '0;
        req.hold_for_drain = 1'b1;
        req_q.insert(req_q.size(), req);
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return $urandom();
        // narrow range to force ties
        if (sel < 80) return 32'($urandom_range(0, 16)) - 32'd8;
        if (sel < 90) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 95) return 32'h7FFF_FFF0 + 32'($urandom_range(0, 15));
        return 32'h8000_0000 + 32'($urandom_range(0, 15));
    endfunction

    assign calm = (cyc >= 4000 && cyc < 9000);

    always @(posedge i_clk) cyc <= cyc + 1;

    // driver
    always @(posedge i_clk) begin
        t_heap_req req;
        bit        take;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            take = !s_tvalid;
            if (s_tvalid && s_tready) begin
                top_expect_q.insert(top_expect_q.size(),
                                    heap_apply(s_tuser[0], $signed(s_tdata)));
                n_accepted++;
                take = 1'b1;
            end
            if (take) begin
                if (req_q.size() > 0 && req_q[0].hold_for_drain && top_expect_q.size() == 0)
                    void'(req_q.pop_front());
                if (req_q.size() > 0 && !req_q[0].hold_for_drain &&
                    (calm || $urandom_range(0, 99) >= 15)) begin
                    req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.value;
                    s_tuser  <= req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_heap_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (top_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transfer: tdata=%h", m_tdata);
                end else begin
                    want = top_expect_q.pop_front();
                    if (m_tdata[31:0] !== want.top || m_tdata[42:32] !== want.count ||
                        m_tdata[43] !== want.empty || m_tdata[45:44] !== want.status) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result %0d mismatch: expected top=%0d count=%0d empty=%0b status=%0d",
                                     n_results, want.top, want.count, want.empty,
                                     want.status);
                            $display("    got top=%0d count=%0d empty=%0b status=%0d",
                                     $signed(m_tdata[31:0]), m_tdata[42:32],
                                     m_tdata[43], m_tdata[45:44]);
                        end
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb_binary_max_heap_queue: errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int bias;
        int k;

        // directed: empty pop, extremes, ties, drain to empty
        queue_item(OP_POP, 32'hFFFF_FFFF);
        queue_item(OP_PUSH, 32'h0000_0000);
        queue_item(OP_POP, 32'h0000_0000);
        queue_item(OP_POP, 32'h1234_5678);
        queue_item(OP_PUSH, 32'h8000_0000);
        queue_item(OP_PUSH, 32'h7FFF_FFFF);
        queue_item(OP_PUSH, 32'hFFFF_FFFF);
        queue_item(OP_PUSH, 32'h0000_0001);
        queue_item(OP_PUSH, 32'h0000_0005);
        queue_item(OP_PUSH, 32'h0000_0005);
        queue_item(OP_PUSH, 32'h0000_0005);
        queue_item(OP_PUSH, 32'h7FFF_FFFF);
        queue_item(OP_PUSH, 32'h8000_0000);
        for (k = 0; k < 10; k++) queue_item(OP_POP, $urandom());

        // random mixes with shifting push bias: grow deep, drain, regrow
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: bias = 90;
                1: bias = 50;
                2: bias = 20;
                3: bias = 85;
                4: bias = 35;
                5: bias = 60;
                default: bias = 30;
            endcase
            for (k = 0; k < 100; k++)
                queue_item(($urandom_range(0, 99) < bias) ? OP_PUSH : OP_POP, pick_value());
            if (phase == 2 || phase == 5) queue_drain_pause();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || top_expect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d transfers in, %0d results out: %0d pushes, %0d pops, peak depth %0d",
                 n_accepted, n_results, n_pushes, n_pops, peak_count);
        $display("rejected: %0d pops on empty, %0d pushes on full; %0d mismatches",
                 n_pop_empty, n_push_full, mismatches);
        if (mismatches == 0 && top_expect_q.size() == 0) begin
            $display("tb_binary_max_heap_queue: clean");
        end else begin
            $display("tb_binary_max_heap_queue: errors");
        end
        $finish;
    end

endmodule
